// File: rtl/vmtc_pkg.sv
// vmtc_pkg: shared constants, codes and types for the valve motor travel controller
// no dependencies; used by every module of the block by scoped names

package vmtc_pkg;

	// field and state widths
	localparam int SENSE_BITS    = 10;
	localparam int TICK_BITS     = 32;
	localparam int POS_BITS      = 8;
	localparam int PHASE_BITS    = 4;
	localparam int STATUS_BITS   = 2;
	localparam int OP_BITS       = 2;
	localparam int DLY_BITS      = 16;
	localparam int TMO_BITS      = 24;
	localparam int CFG_IDX_BITS  = 2;
	localparam int CFG_DATA_BITS = 24;
	localparam int PROD_BITS     = TICK_BITS + POS_BITS;

	localparam logic [TICK_BITS-1:0] TICK_MAX = '1;
	localparam logic [POS_BITS-1:0]  POS_OPEN = '1;
	localparam logic [POS_BITS-1:0]  POS_CLOSED = '0;

	// input opcodes
	localparam logic [OP_BITS-1:0] OP_TICK  = 2'd0;
	localparam logic [OP_BITS-1:0] OP_GOTO  = 2'd1;
	localparam logic [OP_BITS-1:0] OP_CLOSE = 2'd2;
	localparam logic [OP_BITS-1:0] OP_ADAPT = 2'd3;

	// controller phases
	localparam logic [PHASE_BITS-1:0] PH_IDLE      = 4'd0;
	localparam logic [PHASE_BITS-1:0] PH_START     = 4'd1;
	localparam logic [PHASE_BITS-1:0] PH_RUN       = 4'd2;
	localparam logic [PHASE_BITS-1:0] PH_AD_DLY1   = 4'd3;
	localparam logic [PHASE_BITS-1:0] PH_AD_CLOSE1 = 4'd4;
	localparam logic [PHASE_BITS-1:0] PH_AD_DLY2   = 4'd5;
	localparam logic [PHASE_BITS-1:0] PH_AD_OPEN   = 4'd6;
	localparam logic [PHASE_BITS-1:0] PH_AD_DLY3   = 4'd7;
	localparam logic [PHASE_BITS-1:0] PH_AD_CLOSE2 = 4'd8;

	// command status codes
	localparam logic [STATUS_BITS-1:0] ST_OK     = 2'd0;
	localparam logic [STATUS_BITS-1:0] ST_BUSY   = 2'd1;
	localparam logic [STATUS_BITS-1:0] ST_NOMOVE = 2'd2;

	// motor direction
	localparam logic DIR_CLOSE = 1'b0;
	localparam logic DIR_OPEN  = 1'b1;

	// configuration register indexes and reset values
	localparam logic [CFG_IDX_BITS-1:0] CFG_STALL_THR  = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_START_DLY  = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_ADAPT_TMO  = 2'd2;

	localparam logic [SENSE_BITS-1:0] RST_STALL_THR = SENSE_BITS'(70);
	localparam logic [DLY_BITS-1:0]   RST_START_DLY = DLY_BITS'(100);
	localparam logic [TMO_BITS-1:0]   RST_ADAPT_TMO = TMO_BITS'(50000);

	typedef struct packed {
		logic [SENSE_BITS-1:0] stall_threshold;
		logic [DLY_BITS-1:0]   start_delay;
		logic [TMO_BITS-1:0]   adapt_timeout;
	} vmtc_cfg_t;

	typedef struct packed {
		logic                   drive_a;
		logic                   drive_b;
		logic [POS_BITS-1:0]    position;
		logic [PHASE_BITS-1:0]  ctrl_code;
		logic [STATUS_BITS-1:0] cmd_status;
		logic [TICK_BITS-1:0]   open_travel;
		logic [TICK_BITS-1:0]   close_travel;
	} vmtc_res_t;

endpackage

// File: rtl/vmtc_cfg.sv
// vmtc_cfg: configuration registers of the valve motor travel controller
// depends on vmtc_pkg

module vmtc_cfg (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   wr_en,
	input  logic [vmtc_pkg::CFG_IDX_BITS-1:0]      wr_index,
	input  logic [vmtc_pkg::CFG_DATA_BITS-1:0]     wr_data,
	output vmtc_pkg::vmtc_cfg_t                    cfg
);

	vmtc_pkg::vmtc_cfg_t cfg_q;

	// register write decode; writes beyond the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.stall_threshold <= vmtc_pkg::RST_STALL_THR;
			cfg_q.start_delay     <= vmtc_pkg::RST_START_DLY;
			cfg_q.adapt_timeout   <= vmtc_pkg::RST_ADAPT_TMO;
		end else if (wr_en) begin
			unique case (wr_index)
				vmtc_pkg::CFG_STALL_THR: begin
					cfg_q.stall_threshold <= wr_data[vmtc_pkg::SENSE_BITS-1:0];
				end
				vmtc_pkg::CFG_START_DLY: begin
					cfg_q.start_delay <= wr_data[vmtc_pkg::DLY_BITS-1:0];
				end
				vmtc_pkg::CFG_ADAPT_TMO: begin
					cfg_q.adapt_timeout <= wr_data[vmtc_pkg::TMO_BITS-1:0];
				end
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: rtl/vmtc_core.sv
// vmtc_core: controller state and the single-pass update for one item
// depends on vmtc_pkg; fed by the input stage and vmtc_cfg of the top level

module vmtc_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 fire,
	input  logic [vmtc_pkg::OP_BITS-1:0]         opcode,
	input  logic [vmtc_pkg::POS_BITS-1:0]        target_position,
	input  logic [vmtc_pkg::SENSE_BITS-1:0]      current_sample,
	input  vmtc_pkg::vmtc_cfg_t                  cfg,
	output vmtc_pkg::vmtc_res_t                  res
);

	logic [vmtc_pkg::PHASE_BITS-1:0] phase_q, n_phase;
	logic [vmtc_pkg::POS_BITS-1:0]   pos_q, n_pos;
	logic                            dir_q, n_dir;
	logic [vmtc_pkg::POS_BITS-1:0]   goal_q, n_goal;
	logic [vmtc_pkg::TICK_BITS-1:0]  elapsed_q, n_elapsed;
	logic [vmtc_pkg::TICK_BITS-1:0]  run_len_q, n_run_len;
	logic [vmtc_pkg::TICK_BITS-1:0]  open_cal_q, n_open_cal;
	logic [vmtc_pkg::TICK_BITS-1:0]  close_cal_q, n_close_cal;
	logic [vmtc_pkg::STATUS_BITS-1:0] status;

	logic [vmtc_pkg::TICK_BITS-1:0]  elapsed_inc;
	logic [vmtc_pkg::TICK_BITS-1:0]  dly_ext;
	logic [vmtc_pkg::TICK_BITS-1:0]  tmo_ext;
	logic                            stall;
	logic                            delay_done;
	logic                            timed_out;
	logic                            goto_closing;
	logic [vmtc_pkg::POS_BITS-1:0]   goto_dist;
	logic [vmtc_pkg::TICK_BITS-1:0]  goto_cal;
	logic [vmtc_pkg::PROD_BITS-1:0]  goto_prod;
	logic [vmtc_pkg::TICK_BITS-1:0]  goto_len;
	logic [vmtc_pkg::TICK_BITS-1:0]  close_len;
	logic                            active;

	// saturating tick count and the compares a tick needs
	assign elapsed_inc = (elapsed_q == vmtc_pkg::TICK_MAX) ? elapsed_q
		: elapsed_q + vmtc_pkg::TICK_BITS'(1);
	assign dly_ext    = vmtc_pkg::TICK_BITS'(cfg.start_delay);
	assign tmo_ext    = vmtc_pkg::TICK_BITS'(cfg.adapt_timeout);
	assign stall      = current_sample > cfg.stall_threshold;
	assign delay_done = elapsed_inc > dly_ext;
	assign timed_out  = elapsed_inc > run_len_q;

	// goto run length: distance scaled by the calibrated travel, divided by 256
	assign goto_closing = target_position < pos_q;
	assign goto_dist    = goto_closing ? (pos_q - target_position) : (target_position - pos_q);
	assign goto_cal     = goto_closing ? close_cal_q : open_cal_q;
	assign goto_prod    = vmtc_pkg::PROD_BITS'(goto_dist) * vmtc_pkg::PROD_BITS'(goto_cal);
	assign goto_len     = goto_prod[vmtc_pkg::PROD_BITS-1:vmtc_pkg::POS_BITS];

	// close runs twice the closing travel, saturated
	assign close_len = close_cal_q[vmtc_pkg::TICK_BITS-1] ? vmtc_pkg::TICK_MAX
		: {close_cal_q[vmtc_pkg::TICK_BITS-2:0], 1'b0};

	// next state for the item in the input stage
	always_comb begin
		n_phase     = phase_q;
		n_pos       = pos_q;
		n_dir       = dir_q;
		n_goal      = goal_q;
		n_elapsed   = elapsed_q;
		n_run_len   = run_len_q;
		n_open_cal  = open_cal_q;
		n_close_cal = close_cal_q;
		status      = vmtc_pkg::ST_OK;
		case (opcode)
			vmtc_pkg::OP_TICK: begin
				n_elapsed = elapsed_inc;
				unique case (phase_q)
					vmtc_pkg::PH_IDLE: begin
						n_phase = phase_q;
					end
					vmtc_pkg::PH_START: begin
						if (delay_done) n_phase = vmtc_pkg::PH_RUN;
					end
					vmtc_pkg::PH_RUN: begin
						// a timeout on the same tick overrides the end stop
						if (timed_out) begin
							n_phase = vmtc_pkg::PH_IDLE;
							n_pos   = goal_q;
						end else if (stall) begin
							n_phase = vmtc_pkg::PH_IDLE;
							n_pos   = dir_q ? vmtc_pkg::POS_OPEN : vmtc_pkg::POS_CLOSED;
						end
					end
					vmtc_pkg::PH_AD_DLY1: begin
						if (delay_done) n_phase = vmtc_pkg::PH_AD_CLOSE1;
					end
					vmtc_pkg::PH_AD_CLOSE1: begin
						if (stall) begin
							n_dir     = vmtc_pkg::DIR_OPEN;
							n_elapsed = '0;
							n_run_len = tmo_ext;
							n_phase   = vmtc_pkg::PH_AD_DLY2;
						end else if (timed_out) begin
							n_phase     = vmtc_pkg::PH_IDLE;
							n_open_cal  = '0;
							n_close_cal = '0;
						end
					end
					vmtc_pkg::PH_AD_DLY2: begin
						if (delay_done) n_phase = vmtc_pkg::PH_AD_OPEN;
					end
					vmtc_pkg::PH_AD_OPEN: begin
						if (stall) begin
							n_open_cal = elapsed_inc;
							n_dir      = vmtc_pkg::DIR_CLOSE;
							n_elapsed  = '0;
							n_run_len  = tmo_ext;
							n_phase    = vmtc_pkg::PH_AD_DLY3;
						end else if (timed_out) begin
							n_phase     = vmtc_pkg::PH_IDLE;
							n_open_cal  = '0;
							n_close_cal = '0;
						end
					end
					vmtc_pkg::PH_AD_DLY3: begin
						if (delay_done) n_phase = vmtc_pkg::PH_AD_CLOSE2;
					end
					vmtc_pkg::PH_AD_CLOSE2: begin
						// final closing travel has no timeout
						if (stall) begin
							n_close_cal = elapsed_inc;
							n_phase     = vmtc_pkg::PH_IDLE;
							n_pos       = vmtc_pkg::POS_CLOSED;
						end
					end
					default: begin
						n_phase = vmtc_pkg::PH_IDLE;
					end
				endcase
			end
			vmtc_pkg::OP_GOTO: begin
				if (phase_q != vmtc_pkg::PH_IDLE) begin
					status = vmtc_pkg::ST_BUSY;
				end else if (target_position == pos_q) begin
					status = vmtc_pkg::ST_NOMOVE;
				end else begin
					n_dir     = goto_closing ? vmtc_pkg::DIR_CLOSE : vmtc_pkg::DIR_OPEN;
					n_elapsed = '0;
					n_run_len = goto_len;
					n_phase   = vmtc_pkg::PH_START;
					n_goal    = target_position;
				end
			end
			vmtc_pkg::OP_CLOSE: begin
				if (phase_q != vmtc_pkg::PH_IDLE) begin
					status = vmtc_pkg::ST_BUSY;
				end else begin
					n_dir     = vmtc_pkg::DIR_CLOSE;
					n_elapsed = '0;
					n_run_len = close_len;
					n_phase   = vmtc_pkg::PH_START;
					n_goal    = vmtc_pkg::POS_CLOSED;
				end
			end
			default: begin
				// calibration start
				if (phase_q != vmtc_pkg::PH_IDLE) begin
					status = vmtc_pkg::ST_BUSY;
				end else begin
					n_dir     = vmtc_pkg::DIR_CLOSE;
					n_elapsed = '0;
					n_run_len = tmo_ext;
					n_phase   = vmtc_pkg::PH_AD_DLY1;
				end
			end
		endcase
	end

	// state registers, updated once per item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= vmtc_pkg::PH_IDLE;
			pos_q       <= vmtc_pkg::POS_CLOSED;
			dir_q       <= vmtc_pkg::DIR_CLOSE;
			goal_q      <= '0;
			elapsed_q   <= '0;
			run_len_q   <= '0;
			open_cal_q  <= '0;
			close_cal_q <= '0;
		end else if (fire) begin
			phase_q     <= n_phase;
			pos_q       <= n_pos;
			dir_q       <= n_dir;
			goal_q      <= n_goal;
			elapsed_q   <= n_elapsed;
			run_len_q   <= n_run_len;
			open_cal_q  <= n_open_cal;
			close_cal_q <= n_close_cal;
		end
	end

	// result fields as seen after this item
	assign active           = n_phase != vmtc_pkg::PH_IDLE;
	assign res.drive_a      = active && (n_dir == vmtc_pkg::DIR_CLOSE);
	assign res.drive_b      = active && (n_dir == vmtc_pkg::DIR_OPEN);
	assign res.position     = n_pos;
	assign res.ctrl_code    = n_phase;
	assign res.cmd_status   = status;
	assign res.open_travel  = n_open_cal;
	assign res.close_travel = n_close_cal;

endmodule

// File: rtl/valve_motor_travel_controller_top.sv
// valve_motor_travel_controller_top: input stage, result stage and handshakes
// depends on vmtc_pkg, vmtc_cfg and vmtc_core
//
// Usage:
//   Input channel (in_valid / in_stall) carries one item: an opcode (tick,
//   goto, close, calibrate), a target position and a current sample. Each
//   item produces exactly one result on the output channel (out_valid /
//   out_stall): bridge drive legs, position, controller phase, command
//   status and both calibrated travels.
//   Configuration is written through wr_en / wr_index / wr_data, by the user only
//   while the block is idle (not enforced); writes beyond the register list are ignored.
// Timing:
//   An item is registered in the input stage at its transfer; once the result
//   stage can take it, it is updated against the controller state and its result
//   is registered in the result stage, where out_valid rises. One item per cycle is
//   sustained while out_stall stays low; the state update for an item is registered
//   before the next item uses it.
// Reset and stalls:
//   arst_n clears both stages, the controller state and the configuration
//   registers to their defaults. While out_stall holds a waiting result,
//   the input stage still fills once; in_stall rises when both are full.

module valve_motor_travel_controller_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [vmtc_pkg::OP_BITS-1:0]         opcode,
	input  logic [vmtc_pkg::POS_BITS-1:0]        target_position,
	input  logic [vmtc_pkg::SENSE_BITS-1:0]      current_sample,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic                                 drive_a,
	output logic                                 drive_b,
	output logic [vmtc_pkg::POS_BITS-1:0]        position,
	output logic [vmtc_pkg::PHASE_BITS-1:0]      ctrl_code,
	output logic [vmtc_pkg::STATUS_BITS-1:0]     cmd_status,
	output logic [vmtc_pkg::TICK_BITS-1:0]       open_travel,
	output logic [vmtc_pkg::TICK_BITS-1:0]       close_travel,
	input  logic                                 wr_en,
	input  logic [vmtc_pkg::CFG_IDX_BITS-1:0]    wr_index,
	input  logic [vmtc_pkg::CFG_DATA_BITS-1:0]   wr_data
);

	logic                               valid_s1;
	logic [vmtc_pkg::OP_BITS-1:0]       opcode_s1;
	logic [vmtc_pkg::POS_BITS-1:0]      target_s1;
	logic [vmtc_pkg::SENSE_BITS-1:0]    sample_s1;
	logic                               valid_s2;
	vmtc_pkg::vmtc_res_t                res_s2;
	vmtc_pkg::vmtc_res_t                res;
	vmtc_pkg::vmtc_cfg_t                cfg;
	logic                               advance;
	logic                               in_xfer;

	// stage 1 moves on when the result stage is empty or its transfer happens
	assign advance  = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign in_xfer  = in_valid && !in_stall;

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			opcode_s1 <= opcode;
			target_s1 <= target_position;
			sample_s1 <= current_sample;
		end
	end

	vmtc_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cfg      (cfg)
	);

	vmtc_core u_core (
		.clk             (clk),
		.arst_n          (arst_n),
		.fire            (advance),
		.opcode          (opcode_s1),
		.target_position (target_s1),
		.current_sample  (sample_s1),
		.cfg             (cfg),
		.res             (res)
	);

	// result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res;
		end
	end

	assign out_valid    = valid_s2;
	assign drive_a      = res_s2.drive_a;
	assign drive_b      = res_s2.drive_b;
	assign position     = res_s2.position;
	assign ctrl_code    = res_s2.ctrl_code;
	assign cmd_status   = res_s2.cmd_status;
	assign open_travel  = res_s2.open_travel;
	assign close_travel = res_s2.close_travel;

endmodule

// File: rtl/vmtc_checker.sv
// vmtc_checker: port-level assertions for the valve motor travel controller
// depends on vmtc_pkg; attached to valve_motor_travel_controller_top by bind

module vmtc_checker (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 out_valid,
	input logic                                 out_stall,
	input logic                                 drive_a,
	input logic                                 drive_b,
	input logic [vmtc_pkg::POS_BITS-1:0]        position,
	input logic [vmtc_pkg::PHASE_BITS-1:0]      ctrl_code,
	input logic [vmtc_pkg::STATUS_BITS-1:0]     cmd_status
);

	// a stalled result is held until its transfer
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(position) && $stable(ctrl_code))
		else $error("stalled result changed");

	// the bridge never drives both legs
	a_legs: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(drive_a && drive_b))
		else $error("both bridge legs driven");

	// idle means the motor is off, any other phase means it runs
	a_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((ctrl_code == vmtc_pkg::PH_IDLE) == !(drive_a || drive_b)))
		else $error("drive legs disagree with phase");

	// a refused command leaves the controller busy
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (cmd_status == vmtc_pkg::ST_BUSY) |-> ctrl_code != vmtc_pkg::PH_IDLE)
		else $error("busy status while idle");

endmodule

bind valve_motor_travel_controller_top vmtc_checker u_vmtc_checker (.*);

// File: sim/tb_top.sv
`timescale 1ns / 100ps
// tb_top: self-checking testbench for valve_motor_travel_controller_top
// depends on vmtc_pkg and the controller RTL; holds its own bit-true predictor

module tb_top;
	import vmtc_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int PHASE_ITEMS = 155;
	localparam int REPORT_MAX = 10;

	typedef struct packed {
		logic [OP_BITS-1:0]    op;
		logic [POS_BITS-1:0]   tgt;
		logic [SENSE_BITS-1:0] smp;
	} valve_item_t;

	typedef enum {RX_FREE, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_t;

	// clock, reset and block ports
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [OP_BITS-1:0] opcode = OP_TICK;
	logic [POS_BITS-1:0] target_position = '0;
	logic [SENSE_BITS-1:0] current_sample = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic drive_a;
	logic drive_b;
	logic [POS_BITS-1:0] position;
	logic [PHASE_BITS-1:0] ctrl_code;
	logic [STATUS_BITS-1:0] cmd_status;
	logic [TICK_BITS-1:0] open_travel;
	logic [TICK_BITS-1:0] close_travel;
	logic wr_en = 1'b0;
	logic [CFG_IDX_BITS-1:0] wr_index = CFG_STALL_THR;
	logic [CFG_DATA_BITS-1:0] wr_data = '0;

	valve_motor_travel_controller_top DUT (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.opcode          (opcode),
		.target_position (target_position),
		.current_sample  (current_sample),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.drive_a         (drive_a),
		.drive_b         (drive_b),
		.position        (position),
		.ctrl_code       (ctrl_code),
		.cmd_status      (cmd_status),
		.open_travel     (open_travel),
		.close_travel    (close_travel),
		.wr_en           (wr_en),
		.wr_index        (wr_index),
		.wr_data         (wr_data)
	);

	// predictor copy of the configuration and controller state
	logic [SENSE_BITS-1:0] cfg_thr = RST_STALL_THR;
	logic [DLY_BITS-1:0]   cfg_dly = RST_START_DLY;
	logic [TMO_BITS-1:0]   cfg_tmo = RST_ADAPT_TMO;
	logic [PHASE_BITS-1:0] vlv_phase = PH_IDLE;
	logic [POS_BITS-1:0]   vlv_pos = POS_CLOSED;
	logic                  vlv_dir = DIR_CLOSE;
	logic [POS_BITS-1:0]   vlv_goal = POS_CLOSED;
	logic [TICK_BITS-1:0]  vlv_elapsed = '0;
	logic [TICK_BITS-1:0]  vlv_runlen = '0;
	logic [TICK_BITS-1:0]  cal_open = '0;
	logic [TICK_BITS-1:0]  cal_close = '0;

	valve_item_t item_q[$];
	vmtc_res_t   pending_res[$];
	int queued;
	int errors = 0;
	int res_count = 0;
	int unsigned cycles = 0;
	bit took = 1'b0;
	int gap_left = 0;
	int burst_left = 0;
	int stall_seg = 0;
	rx_mode_t stall_mode = RX_FREE;

	initial begin
		forever #2 clk = ~clk;
	end

	function automatic void start_run(logic dir, logic [TICK_BITS-1:0] len,
		logic [PHASE_BITS-1:0] ph);
		vlv_dir = dir;
		vlv_elapsed = '0;
		vlv_runlen = len;
		vlv_phase = ph;
	endfunction

	// calibration travel ran out of time: stop and forget both travels
	function automatic void abort_adapt();
		vlv_phase = PH_IDLE;
		cal_open = '0;
		cal_close = '0;
	endfunction

	// next controller state and the result for one transfer
	function automatic vmtc_res_t valve_step(logic [OP_BITS-1:0] op, logic [POS_BITS-1:0] tgt,
		logic [SENSE_BITS-1:0] smp);
		vmtc_res_t r;
		logic stall;
		logic active;
		logic [STATUS_BITS-1:0] st;
		logic [POS_BITS-1:0] span;
		logic [PROD_BITS-1:0] prod;
		logic [TICK_BITS:0] dbl;
		st = ST_OK;
		case (op)
			OP_TICK: begin
				if (vlv_elapsed != TICK_MAX)
					vlv_elapsed = vlv_elapsed + 1;
				stall = smp > cfg_thr;
				case (vlv_phase)
					PH_IDLE: ;
					PH_START: if (vlv_elapsed > cfg_dly) vlv_phase = PH_RUN;
					PH_RUN: begin
						if (stall) begin
							vlv_phase = PH_IDLE;
							vlv_pos = (vlv_dir == DIR_OPEN) ? POS_OPEN : POS_CLOSED;
						end
						// timeout checked last, so it wins over the end stop
						if (vlv_elapsed > vlv_runlen) begin
							vlv_phase = PH_IDLE;
							vlv_pos = vlv_goal;
						end
					end
					PH_AD_DLY1: if (vlv_elapsed > cfg_dly) vlv_phase = PH_AD_CLOSE1;
					PH_AD_CLOSE1: begin
						if (stall) start_run(DIR_OPEN, TICK_BITS'(cfg_tmo), PH_AD_DLY2);
						if (vlv_elapsed > vlv_runlen) abort_adapt();
					end
					PH_AD_DLY2: if (vlv_elapsed > cfg_dly) vlv_phase = PH_AD_OPEN;
					PH_AD_OPEN: begin
						if (stall) begin
							cal_open = vlv_elapsed;
							start_run(DIR_CLOSE, TICK_BITS'(cfg_tmo), PH_AD_DLY3);
						end
						if (vlv_elapsed > vlv_runlen) abort_adapt();
					end
					PH_AD_DLY3: if (vlv_elapsed > cfg_dly) vlv_phase = PH_AD_CLOSE2;
					PH_AD_CLOSE2: begin
						if (stall) begin
							cal_close = vlv_elapsed;
							vlv_phase = PH_IDLE;
							vlv_pos = POS_CLOSED;
						end
					end
					default: vlv_phase = PH_IDLE;
				endcase
			end
			OP_GOTO: begin
				if (vlv_phase != PH_IDLE) begin
					st = ST_BUSY;
				end else if (tgt == vlv_pos) begin
					st = ST_NOMOVE;
				end else begin
					// 8-bit distance times 32-bit travel, shifted by 8, always fits 32 bits
					if (tgt < vlv_pos) begin
						span = vlv_pos - tgt;
						prod = PROD_BITS'(span) * PROD_BITS'(cal_close);
						start_run(DIR_CLOSE, prod[PROD_BITS-1:POS_BITS], PH_START);
					end else begin
						span = tgt - vlv_pos;
						prod = PROD_BITS'(span) * PROD_BITS'(cal_open);
						start_run(DIR_OPEN, prod[PROD_BITS-1:POS_BITS], PH_START);
					end
					vlv_goal = tgt;
				end
			end
			OP_CLOSE: begin
				if (vlv_phase != PH_IDLE) begin
					st = ST_BUSY;
				end else begin
					dbl = {cal_close, 1'b0};
					start_run(DIR_CLOSE, dbl[TICK_BITS] ? TICK_MAX : dbl[TICK_BITS-1:0],
						PH_START);
					vlv_goal = POS_CLOSED;
				end
			end
			default: begin
				if (vlv_phase != PH_IDLE)
					st = ST_BUSY;
				else
					start_run(DIR_CLOSE, TICK_BITS'(cfg_tmo), PH_AD_DLY1);
			end
		endcase
		active = vlv_phase != PH_IDLE;
		r.drive_a = active && vlv_dir == DIR_CLOSE;
		r.drive_b = active && vlv_dir == DIR_OPEN;
		r.position = vlv_pos;
		r.ctrl_code = vlv_phase;
		r.cmd_status = st;
		r.open_travel = cal_open;
		r.close_travel = cal_close;
		return r;
	endfunction

	// stimulus helpers
	task automatic push_item(logic [OP_BITS-1:0] op, logic [POS_BITS-1:0] tgt,
		logic [SENSE_BITS-1:0] smp);
		valve_item_t it;
		it.op = op;
		it.tgt = tgt;
		it.smp = smp;
		item_q.push_back(it);
		queued++;
	endtask

	function automatic logic [SENSE_BITS-1:0] quiet_sample();
		return SENSE_BITS'($urandom_range(int'(cfg_thr), 0));
	endfunction

	function automatic logic [SENSE_BITS-1:0] stall_sample();
		if (cfg_thr == '1)
			return '1;
		return SENSE_BITS'($urandom_range(1023, int'(cfg_thr) + 1));
	endfunction

	// one motor travel: start delay, some quiet ticks with the odd goto, then maybe an end stop
	task automatic travel(int quiet, bit hit_stop);
		int lead;
		lead = (cfg_dly > 11) ? 12 : int'(cfg_dly) + 1;
		repeat (lead + quiet) begin
			if ($urandom_range(19, 0) == 0)
				push_item(OP_GOTO, POS_BITS'($urandom_range(255, 0)), quiet_sample());
			else
				push_item(OP_TICK, POS_BITS'($urandom_range(255, 0)), quiet_sample());
		end
		if (hit_stop)
			push_item(OP_TICK, POS_BITS'($urandom_range(255, 0)), stall_sample());
	endtask

	task automatic adapt_run();
		push_item(OP_ADAPT, POS_BITS'($urandom_range(255, 0)), quiet_sample());
		for (int leg = 0; leg < 3; leg++) begin
			// now and then let a calibration travel run out of time
			if (leg < 2 && cfg_tmo <= 60 && $urandom_range(7, 0) == 0) begin
				travel(int'(cfg_tmo) + 2, 1'b0);
				return;
			end
			travel($urandom_range(8, 0), 1'b1);
		end
	endtask

	task automatic noise_burst();
		repeat ($urandom_range(6, 1))
			push_item(OP_BITS'($urandom_range(3, 0)), POS_BITS'($urandom_range(255, 0)),
				SENSE_BITS'($urandom_range(1023, 0)));
	endtask

	task automatic cfg_write(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
		@(negedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		case (idx)
			CFG_STALL_THR: cfg_thr = val[SENSE_BITS-1:0];
			CFG_START_DLY: cfg_dly = val[DLY_BITS-1:0];
			CFG_ADAPT_TMO: cfg_tmo = val[TMO_BITS-1:0];
			default: ;
		endcase
		@(negedge clk);
		wr_en <= 1'b0;
	endtask

	// hold off until every queued item has come back
	task automatic drain();
		while (item_q.size() != 0 || pending_res.size() != 0 || in_valid)
			@(posedge clk);
		repeat (4) @(negedge clk);
	endtask

	// input driver: bursts of transfers with random gaps
	always @(negedge clk) begin
		valve_item_t it;
		if (!in_valid || took) begin
			took = 1'b0;
			if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (item_q.size() != 0) begin
				it = item_q.pop_front();
				in_valid <= 1'b1;
				opcode <= it.op;
				target_position <= it.tgt;
				current_sample <= it.smp;
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(24, 1);
					gap_left = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(9, 1);
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// output stall pattern: free, light, heavy and periodic stretches
	always @(negedge clk) begin
		if (stall_seg == 0) begin
			stall_mode = rx_mode_t'($urandom_range(3, 0));
			stall_seg = $urandom_range(60, 5);
		end
		stall_seg--;
		case (stall_mode)
			RX_FREE: out_stall <= 1'b0;
			RX_LIGHT: out_stall <= ($urandom_range(3, 0) == 0);
			RX_HEAVY: out_stall <= ($urandom_range(9, 0) < 7);
			default: out_stall <= (stall_seg % 4 != 0);
		endcase
	end

	// input transfers feed the predictor
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall) begin
			pending_res.push_back(valve_step(opcode, target_position, current_sample));
			took = 1'b1;
		end
	end

	// result transfers are checked against the oldest prediction
	always @(posedge clk) begin
		vmtc_res_t want;
		if (arst_n && out_valid && !out_stall) begin
			res_count++;
			if (pending_res.size() == 0) begin
				errors++;
				if (errors <= REPORT_MAX)
					$display("result %0d arrived with nothing predicted", res_count);
			end else begin
				want = pending_res.pop_front();
				if (drive_a !== want.drive_a || drive_b !== want.drive_b ||
						position !== want.position || ctrl_code !== want.ctrl_code ||
						cmd_status !== want.cmd_status || open_travel !== want.open_travel ||
						close_travel !== want.close_travel) begin
					errors++;
					if (errors <= REPORT_MAX)
						$display({"result %0d mismatch: exp a%b b%b pos %0d ph %0d st %0d ",
							"ot %0d ct %0d / got a%b b%b pos %0d ph %0d st %0d ot %0d ct %0d"},
							res_count, want.drive_a, want.drive_b, want.position,
							want.ctrl_code, want.cmd_status, want.open_travel,
							want.close_travel, drive_a, drive_b, position, ctrl_code,
							cmd_status, open_travel, close_travel);
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// reset, directed items, then randomized phases with fresh settings
	initial begin
		int thr;
		int dly;
		int tmo;
		int quota;
		int pick;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset values: idle ticks, goto onto the current spot, busy answers
		push_item(OP_TICK, 8'h00, 10'h000);
		push_item(OP_TICK, 8'hFF, 10'h3FF);
		push_item(OP_GOTO, 8'h00, 10'h000);
		push_item(OP_GOTO, 8'hFF, 10'h000);
		push_item(OP_GOTO, 8'hAA, 10'h155);
		push_item(OP_CLOSE, 8'h55, 10'h2AA);
		push_item(OP_ADAPT, 8'h00, 10'h000);
		push_item(OP_TICK, 8'h00, 10'h3FF);
		drain();

		cfg_write(CFG_STALL_THR, 24'd512);
		cfg_write(CFG_START_DLY, 24'd0);
		cfg_write(CFG_ADAPT_TMO, 24'd40);
		cfg_write(2'd3, 24'hFFFFFF);
		// finish the uncalibrated run, then a full calibration
		push_item(OP_TICK, 8'h00, 10'h000);
		push_item(OP_TICK, 8'h00, 10'h000);
		push_item(OP_ADAPT, 8'h00, 10'h000);
		push_item(OP_TICK, 8'h00, 10'h000);
		push_item(OP_TICK, 8'h00, 10'h3FF);
		push_item(OP_TICK, 8'h00, 10'h000);
		push_item(OP_TICK, 8'h00, 10'h000);
		push_item(OP_TICK, 8'h00, 10'd600);
		push_item(OP_TICK, 8'h00, 10'h000);
		push_item(OP_TICK, 8'h00, 10'h000);
		push_item(OP_TICK, 8'h00, 10'h3FF);
		// goto ending on timeout, close ending on a stall
		push_item(OP_GOTO, 8'h80, 10'h000);
		push_item(OP_TICK, 8'h00, 10'h000);
		push_item(OP_TICK, 8'h00, 10'h000);
		push_item(OP_CLOSE, 8'h00, 10'h000);
		push_item(OP_TICK, 8'h00, 10'h000);
		push_item(OP_TICK, 8'h00, 10'h3FF);
		// stall and timeout on the same tick: the goal wins
		push_item(OP_GOTO, 8'hFF, 10'h000);
		push_item(OP_TICK, 8'h00, 10'h000);
		push_item(OP_TICK, 8'h00, 10'h000);
		push_item(OP_TICK, 8'h00, 10'h3FF);
		drain();

		for (int p = 0; p < 10; p++) begin
			thr = (p == 0) ? 0 : (p == 1) ? 1023 : $urandom_range(900, 40);
			dly = (p == 2) ? 65535 : $urandom_range(3, 0);
			tmo = (p == 3) ? 16777215 : (p == 4) ? 0 : $urandom_range(40, 4);
			quota = (p == 2) ? 60 : PHASE_ITEMS;
			cfg_write(CFG_STALL_THR, CFG_DATA_BITS'(thr));
			cfg_write(CFG_START_DLY, CFG_DATA_BITS'(dly));
			cfg_write(CFG_ADAPT_TMO, CFG_DATA_BITS'(tmo));
			queued = 0;
			while (queued < quota) begin
				pick = $urandom_range(99, 0);
				if (pick < 35) begin
					adapt_run();
				end else if (pick < 65) begin
					push_item(OP_GOTO, ($urandom_range(9, 0) == 0) ?
						POS_BITS'(($urandom_range(1, 0) == 0) ? 0 : 255) :
						POS_BITS'($urandom_range(255, 0)), quiet_sample());
					travel($urandom_range(24, 0), $urandom_range(2, 0) != 0);
				end else if (pick < 80) begin
					push_item(OP_CLOSE, POS_BITS'($urandom_range(255, 0)), quiet_sample());
					travel($urandom_range(40, 0), $urandom_range(3, 0) != 0);
				end else begin
					noise_burst();
				end
			end
			drain();
		end

		repeat (8) @(posedge clk);
		if (errors == 0 && pending_res.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// File: files.f
rtl/vmtc_pkg.sv
rtl/vmtc_cfg.sv
rtl/vmtc_core.sv
rtl/valve_motor_travel_controller_top.sv
rtl/vmtc_checker.sv
sim/tb_top.sv
